>>> src/rgb_grayscale_histogram_macros.svh
// ----------------------------------------------------------------------------
// rgb_grayscale_histogram assertion macros
// Shared property forms for the grayscale histogram block. The macros expect
// signals named clk and arst_n in the scope that uses them.
// ----------------------------------------------------------------------------
`ifndef RGB_GRAYSCALE_HISTOGRAM_MACROS_SVH
`define RGB_GRAYSCALE_HISTOGRAM_MACROS_SVH

// Check that a condition implies another in the same cycle
`define RGH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check that a condition implies another in the following cycle
`define RGH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rgh_pkg.sv
// ----------------------------------------------------------------------------
// rgh_pkg
// Constants shared by the grayscale histogram block and its bin memory.
// ----------------------------------------------------------------------------
package rgh_pkg;

	// Histogram geometry
	localparam int COUNT_BITS     = 20;
	localparam int NUM_BINS       = 256;
	localparam int BIN_BITS       = $clog2(NUM_BINS);
	localparam int PIX_BITS       = 8;
	localparam int OUT_COUNT_BITS = 20;

	// Luma weights and divisor (BT.601, scaled by 1000)
	localparam int SUM_BITS = 18;
	localparam logic [SUM_BITS-1:0] W_RED   = SUM_BITS'(299);
	localparam logic [SUM_BITS-1:0] W_GREEN = SUM_BITS'(587);
	localparam logic [SUM_BITS-1:0] W_BLUE  = SUM_BITS'(114);
	localparam int DIVISOR = 1000;

	// Reciprocal for the divide: floor(s * RECIP / 2^RECIP_SHIFT) equals
	// floor(s / 1000) for every weighted sum that 8-bit pixels can produce
	localparam int RECIP_SHIFT = 28;
	localparam int RECIP_VAL   = ((1 << RECIP_SHIFT) + DIVISOR - 1) / DIVISOR;
	localparam int RECIP_BITS  = 19;
	localparam int PROD_BITS   = SUM_BITS + RECIP_BITS;
	localparam logic [PROD_BITS-1:0] RECIP = PROD_BITS'(RECIP_VAL);

	// Saturation value of a bin
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// Opcodes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [BIN_BITS-1:0]   bin_t;

endpackage

>>> src/rgh_ram.sv
// ----------------------------------------------------------------------------
// rgh_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read and read enable. A read of the address written in the
// same cycle returns the old contents.
// ----------------------------------------------------------------------------
module rgh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/rgb_grayscale_histogram.sv
// ----------------------------------------------------------------------------
// rgb_grayscale_histogram
// Converts RGB pixels to BT.601 gray levels and keeps a 256-bin histogram.
// ----------------------------------------------------------------------------
// Takes one item per clock unless res_ready stalls the output, and returns one
// result per item. Opcode 0 converts a pixel to gray = (299R + 587G + 114B) /
// 1000 and counts it in that gray level's bin; opcode 1 returns one bin's
// count and clears it. Bins saturate at their maximum. The bins live in one
// 256-entry RAM that is read one stage and written back the next, so the rate
// is set by that read-modify-write loop, which forwards the previous item's
// write so that back-to-back hits on one bin count correctly. A valid bit per
// bin makes the histogram read as zero right after reset; there is no clearing
// pass and items are accepted from the first cycle after reset.
// ----------------------------------------------------------------------------
`include "rgb_grayscale_histogram_macros.svh"

module rgb_grayscale_histogram (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cmd_valid,
	output logic                               cmd_ready,
	input  logic                               opcode,
	input  logic [rgh_pkg::PIX_BITS-1:0]       red,
	input  logic [rgh_pkg::PIX_BITS-1:0]       green,
	input  logic [rgh_pkg::PIX_BITS-1:0]       blue,
	input  logic [rgh_pkg::BIN_BITS-1:0]       bin_index,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic [rgh_pkg::PIX_BITS-1:0]       gray,
	output logic [rgh_pkg::OUT_COUNT_BITS-1:0] bin_count
);

	import rgh_pkg::*;

	logic                      adv;
	logic [SUM_BITS-1:0]       sum_c;
	logic [PROD_BITS-1:0]      prod_c;
	logic [PIX_BITS-1:0]       gray_c;
	bin_t                      addr_c;

	logic                      valid_s1, valid_s2, valid_s3;
	logic                      op_s1, op_s2, op_s3;
	logic [SUM_BITS-1:0]       sum_s1;
	bin_t                      idx_s1;
	bin_t                      addr_s2, addr_s3;
	logic                      fwd_s3;
	count_t                    fwd_data_s3;
	logic                      vld_s3;

	logic [NUM_BINS-1:0]       vld_q;
	count_t                    ram_rd;
	count_t                    cur_c;
	count_t                    wr_data;
	logic                      wr_en;

	logic                      res_valid_q;
	logic [PIX_BITS-1:0]       gray_q;
	logic [OUT_COUNT_BITS-1:0] count_q;

	// Advance the whole pipeline when the output register can take an item
	assign adv       = !res_valid_q || res_ready;
	assign cmd_ready = adv;

	// Weighted sum of the color components
	assign sum_c = SUM_BITS'(red) * W_RED + SUM_BITS'(green) * W_GREEN
		+ SUM_BITS'(blue) * W_BLUE;

	// Divide by 1000 through the reciprocal, pick the bin address
	assign prod_c = PROD_BITS'(sum_s1) * RECIP;
	assign gray_c = prod_c[RECIP_SHIFT +: PIX_BITS];
	assign addr_c = (op_s1 == OP_READ) ? idx_s1 : BIN_BITS'(gray_c);

	// Stage 1: capture the command and the weighted sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s1  <= opcode;
			sum_s1 <= sum_c;
			idx_s1 <= bin_index;
		end
	end

	// Stage 2: hold the bin address while its RAM read is issued
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s2   <= op_s1;
			addr_s2 <= addr_c;
		end
	end

	// Bin memory: read for stage 2, write back from stage 3
	assign wr_en = adv && valid_s3;

	rgh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_BINS)
	) u_bins (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s3),
		.wdata (wr_data),
		.re    (adv),
		.raddr (addr_s2),
		.rdata (ram_rd)
	);

	// Stage 3: capture forwarding and bin valid state alongside the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			fwd_s3   <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
			fwd_s3   <= valid_s3 && (addr_s3 == addr_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			op_s3       <= op_s2;
			addr_s3     <= addr_s2;
			fwd_data_s3 <= wr_data;
			vld_s3      <= vld_q[addr_s2];
		end
	end

	// Mark bins as written; an unmarked bin reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[addr_s3] <= 1'b1;
		end
	end

	// Modify: increment with saturation, or clear on a read
	assign cur_c = fwd_s3 ? fwd_data_s3 : (vld_s3 ? ram_rd : '0);

	always_comb begin
		if (op_s3 == OP_READ) begin
			wr_data = '0;
		end else if (cur_c == COUNT_MAX) begin
			wr_data = cur_c;
		end else begin
			wr_data = cur_c + 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			gray_q  <= (op_s3 == OP_PIXEL) ? PIX_BITS'(addr_s3) : '0;
			count_q <= (op_s3 == OP_READ) ? OUT_COUNT_BITS'(cur_c) : '0;
		end
	end

	assign res_valid = res_valid_q;
	assign gray      = gray_q;
	assign bin_count = count_q;

	// Back-to-back items on one bin must take the forwarded count
	`RGH_ASSERT_NEXT(a_fwd_hazard, adv && valid_s2 && valid_s3 && (addr_s2 == addr_s3), fwd_s3, "same-bin hazard not forwarded")
	// A counted pixel never writes a zero count back
	`RGH_ASSERT_SAME(a_count_nonzero, wr_en && (op_s3 == OP_PIXEL), wr_data != '0, "pixel wrote a zero bin count")
	// A result carries either a gray value or a bin count, never both
	`RGH_ASSERT_SAME(a_result_exclusive, res_valid, (gray == '0) || (bin_count == '0), "result has both gray and count")

endmodule
